// ===== hdl/dtd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dtd_pkg;

    // Message type codes.
    localparam logic [7:0] CMD_TIME   = 8'h54;
    localparam logic [7:0] CMD_DATE   = 8'h44;
    localparam logic [7:0] CMD_RESEND = 8'h72;

    // Reply codes.
    localparam logic [7:0] REPLY_OK  = 8'h4F;
    localparam logic [7:0] REPLY_BAD = 8'h72;

    // Fixed seconds value written with every time update.
    localparam logic [7:0] FIXED_SEC = 8'd55;

    // Range limits of the set commands.
    localparam logic [7:0]  HOUR_MAX   = 8'd23;
    localparam logic [7:0]  MINUTE_MAX = 8'd59;
    localparam logic [7:0]  DAY_MIN    = 8'd1;
    localparam logic [7:0]  DAY_MAX    = 8'd31;
    localparam logic [7:0]  MONTH_MIN  = 8'd1;
    localparam logic [7:0]  MONTH_MAX  = 8'd12;
    localparam logic [15:0] YEAR_MIN   = 16'd1980;
    localparam logic [15:0] YEAR_MAX   = 16'd2099;
    localparam logic [15:0] YEAR_BASE  = 16'd2000;

    // Command request payload.
    typedef struct packed {
        logic [7:0]  func;
        logic [7:0]  first_value;
        logic [7:0]  second_value;
        logic [15:0] year_value;
    } t_cmd;

    // Result request payload.
    typedef struct packed {
        logic [7:0] reply_code;
        logic       time_write;
        logic       date_write;
        logic [7:0] second_bcd;
        logic [7:0] minute_bcd;
        logic [7:0] hour_bcd;
        logic [2:0] weekday;
        logic [7:0] day_bcd;
        logic [7:0] month_bcd;
        logic [7:0] year_bcd;
    } t_rsp;

endpackage

`default_nettype wire

// ===== hdl/dtd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Command channel.
interface dtd_cmd_if import dtd_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel.
interface dtd_rsp_if import dtd_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/date_time_set_command_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Date and time set command decoder.
// A command request (type byte, two value bytes, 16-bit year) enters on
// i_cmd; one result request per command leaves on o_rsp. Both channels use
// valid/ready and move a request at a clock edge where both are high.
// The command is captured in an input register, decoded, range checked and
// converted to BCD by one level of logic, and loaded into the result
// register, which drives o_rsp.valid and o_rsp.data; one command per cycle
// is taken while results are drained. A resend command repeats the last
// reply, kept in a reply register that is updated in command order as
// each result is formed.
// Synchronous active-low reset empties both registers and clears the last
// reply to zero. When the receiver holds o_rsp.ready low, the result
// register holds, then the input register fills, and i_cmd.ready drops; no
// request is lost or repeated.
module date_time_set_command_decoder import dtd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dtd_cmd_if.sink    i_cmd,
    dtd_rsp_if.source  o_rsp
);

    logic       r_in_valid;
    t_cmd       r_in;
    logic       r_out_valid;
    t_rsp       r_out;
    logic [7:0] r_last_reply;
    t_rsp       n_out;
    logic       out_load;
    logic       in_load;

    // Stage advance control.
    assign out_load    = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_load     = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_in_valid || out_load;

    dtd_calc u_calc (
        .i_cmd        (r_in),
        .i_last_reply (r_last_reply),
        .o_rsp        (n_out)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_reply <= 8'd0;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_last_reply <= n_out.reply_code;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in <= i_cmd.data;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

// ===== hdl/dtd_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtd_calc import dtd_pkg::*; (
    input  wire t_cmd       i_cmd,
    input  wire logic [7:0] i_last_reply,
    output t_rsp            o_rsp
);

    // Binary to BCD for one byte; the tens digit keeps only its low nibble.
    function automatic logic [7:0] bcd8(input logic [7:0] v);
        logic [18:0] prod;
        logic [7:0]  tens;
        logic [7:0]  ones;
        prod = {11'd0, v} * 19'd205;
        tens = {3'd0, prod[15:11]};
        ones = v - 8'(tens * 8'd10);
        return {tens[3:0], ones[3:0]};
    endfunction

    // Month term of the weekday formula: 23 * m / 9.
    function automatic logic [4:0] month_term(input logic [3:0] m);
        logic [4:0] t;
        case (m)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd17;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd30;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

    // Residue mod 7 of a 12-bit value by folding octal digits (8 is 1 mod 7).
    function automatic logic [2:0] mod7(input logic [11:0] v);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[11:9]);
        s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

    logic        time_ok;
    logic        date_ok;
    logic        is_time;
    logic        is_date;
    logic        early;
    logic [11:0] yr;
    logic [11:0] y_adj;
    logic [11:0] d_adj;
    logic [11:0] wsum;
    logic [2:0]  wday;
    logic [7:0]  year_off;

    // Range checks.
    assign is_time = (i_cmd.func == CMD_TIME);
    assign is_date = (i_cmd.func == CMD_DATE);
    assign time_ok = is_time && (i_cmd.first_value <= HOUR_MAX)
                     && (i_cmd.second_value <= MINUTE_MAX);
    assign date_ok = is_date
                     && (i_cmd.first_value >= DAY_MIN) && (i_cmd.first_value <= DAY_MAX)
                     && (i_cmd.second_value >= MONTH_MIN)
                     && (i_cmd.second_value <= MONTH_MAX)
                     && (i_cmd.year_value >= YEAR_MIN) && (i_cmd.year_value <= YEAR_MAX);

    // Weekday. January and February count to the previous year. Over the
    // accepted years the century terms y/400 - y/100 + 4 always total -11,
    // which is 3 mod 7, so only y/4 remains as a year-dependent division.
    assign yr    = i_cmd.year_value[11:0];
    assign early = (i_cmd.second_value < 8'd3);
    assign y_adj = early ? (yr - 12'd1) : yr;
    assign d_adj = early ? (12'(i_cmd.first_value) + yr)
                         : (12'(i_cmd.first_value) + yr - 12'd2);
    assign wsum  = 12'(month_term(i_cmd.second_value[3:0])) + d_adj
                   + {2'd0, y_adj[11:2]} + 12'd3;
    assign wday  = mod7(wsum) + 3'd1;

    assign year_off = i_cmd.year_value[7:0] - YEAR_BASE[7:0];

    // Result assembly; fields not written stay zero.
    always_comb begin
        o_rsp = '0;
        if (time_ok || date_ok) begin
            o_rsp.reply_code = REPLY_OK;
        end else if (i_cmd.func == CMD_RESEND) begin
            o_rsp.reply_code = i_last_reply;
        end else begin
            o_rsp.reply_code = REPLY_BAD;
        end
        if (time_ok) begin
            o_rsp.time_write = 1'b1;
            o_rsp.second_bcd = FIXED_SEC;
            o_rsp.minute_bcd = bcd8(i_cmd.second_value);
            o_rsp.hour_bcd   = bcd8(i_cmd.first_value);
        end
        if (date_ok) begin
            o_rsp.date_write = 1'b1;
            o_rsp.weekday    = wday;
            o_rsp.day_bcd    = bcd8(i_cmd.first_value);
            o_rsp.month_bcd  = bcd8(i_cmd.second_value);
            o_rsp.year_bcd   = bcd8(year_off);
        end
    end

endmodule

`default_nettype wire

// ===== tb/dtd_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the date/time set command decoder, predicts each
// result request from the accepted command requests and compares the results
// in order.
module dtd_checker import dtd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dtd_cmd_if        i_cmd_mon,
    dtd_rsp_if        i_rsp_mon,
    output int        o_fail_count,
    output int        o_pending
);

    // Results still owed by the block, oldest first.
    t_rsp       expected_rsp_q[$];
    logic [7:0] last_reply_q = '0;
    int         fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Binary to packed BCD of the low byte, cut back to eight bits.
    function automatic logic [7:0] to_bcd(input int unsigned value);
        int unsigned b;
        b = value & 32'hFF;
        return 8'((((b / 10) << 4) | (b % 10)) & 32'hFF);
    endfunction

    // Day of week by Keith's formula, 1 is Sunday. The day plus year sum is
    // kept at full width.
    function automatic logic [2:0] day_of_week(input int unsigned day,
                                               input int unsigned month,
                                               input int unsigned year);
        int unsigned d;
        int unsigned y;
        int unsigned sum;
        d = day;
        y = year;
        if (month < 3) begin
            d = d + y;
            y = y - 1;
        end else begin
            d = d + y - 2;
        end
        sum = (23 * month / 9) + d + 4 + (y / 4) - (y / 100) + (y / 400);
        return 3'((sum % 7) + 1);
    endfunction

    // Expected result of one set command, given the reply held so far.
    function automatic t_rsp decode_cmd(input t_cmd cmd, input logic [7:0] prev_reply);
        t_rsp r;
        int unsigned yr;
        r            = '0;
        r.reply_code = prev_reply;
        yr           = int'(cmd.year_value);
        if (cmd.func == CMD_TIME) begin
            if (cmd.first_value <= HOUR_MAX && cmd.second_value <= MINUTE_MAX) begin
                r.reply_code = REPLY_OK;
                r.time_write = 1'b1;
                r.second_bcd = FIXED_SEC;
                r.minute_bcd = to_bcd(int'(cmd.second_value));
                r.hour_bcd   = to_bcd(int'(cmd.first_value));
            end else begin
                r.reply_code = REPLY_BAD;
            end
        end else if (cmd.func == CMD_DATE) begin
            if (cmd.first_value >= DAY_MIN && cmd.first_value <= DAY_MAX &&
                cmd.second_value >= MONTH_MIN && cmd.second_value <= MONTH_MAX &&
                cmd.year_value >= YEAR_MIN && cmd.year_value <= YEAR_MAX) begin
                r.reply_code = REPLY_OK;
                r.date_write = 1'b1;
                r.weekday    = day_of_week(int'(cmd.first_value),
                                           int'(cmd.second_value), yr);
                r.day_bcd    = to_bcd(int'(cmd.first_value));
                r.month_bcd  = to_bcd(int'(cmd.second_value));
                r.year_bcd   = to_bcd((yr - int'(YEAR_BASE)) & 32'hFF);
            end else begin
                r.reply_code = REPLY_BAD;
            end
        end else if (cmd.func != CMD_RESEND) begin
            r.reply_code = REPLY_BAD;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    // Results are checked before the command of the same edge is queued, so
    // a result can never be matched with a command taken at that same edge.
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            expected_rsp_q.delete();
            last_reply_q = '0;
        end else begin
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got = i_rsp_mon.data;
                if (expected_rsp_q.size() == 0) begin
                    $error("result request with no command pending: reply_code %0h",
                           got.reply_code);
                    fails++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    check_field("reply_code", want.reply_code, got.reply_code);
                    check_field("time_write", want.time_write, got.time_write);
                    check_field("date_write", want.date_write, got.date_write);
                    check_field("second_bcd", want.second_bcd, got.second_bcd);
                    check_field("minute_bcd", want.minute_bcd, got.minute_bcd);
                    check_field("hour_bcd", want.hour_bcd, got.hour_bcd);
                    check_field("weekday", want.weekday, got.weekday);
                    check_field("day_bcd", want.day_bcd, got.day_bcd);
                    check_field("month_bcd", want.month_bcd, got.month_bcd);
                    check_field("year_bcd", want.year_bcd, got.year_bcd);
                end
            end
            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                want         = decode_cmd(i_cmd_mon.data, last_reply_q);
                last_reply_q = want.reply_code;
                expected_rsp_q.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_rsp_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Top of the decoder testbench: clock, reset, command stimulus, result
// back-pressure and the verdict.
module tb;
    import dtd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   tx_quiet;
    bit   rx_quiet;

    dtd_cmd_if cmd_if ();
    dtd_rsp_if rsp_if ();

    date_time_set_command_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    dtd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_mon    (cmd_if),
        .i_rsp_mon    (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Guard against a hung handshake.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int gap_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(4, 20));
    endfunction

    function automatic t_cmd make_cmd(input logic [7:0] func, input logic [7:0] first,
                                      input logic [7:0] second, input logic [15:0] year);
        t_cmd c;
        c.func         = func;
        c.first_value  = first;
        c.second_value = second;
        c.year_value   = year;
        return c;
    endfunction

    // Mostly well-formed time and date commands, some resends and noise.
    function automatic t_cmd random_cmd();
        t_cmd c;
        int unsigned pick;
        pick   = $urandom_range(0, 99);
        c.func         = 8'($urandom);
        c.first_value  = 8'($urandom);
        c.second_value = 8'($urandom);
        c.year_value   = 16'($urandom);
        if (pick < 35) begin
            c.func         = CMD_TIME;
            c.first_value  = 8'($urandom_range(0, 23));
            c.second_value = 8'($urandom_range(0, 59));
        end else if (pick < 70) begin
            c.func         = CMD_DATE;
            c.first_value  = 8'($urandom_range(1, 31));
            c.second_value = 8'($urandom_range(1, 12));
            c.year_value   = 16'($urandom_range(1980, 2099));
        end else if (pick < 80) begin
            c.func = CMD_RESEND;
        end else if (pick < 90) begin
            // Known type with values over the full range, mostly rejected.
            c.func = ($urandom_range(0, 1) == 1) ? CMD_TIME : CMD_DATE;
        end
        return c;
    endfunction

    // Offer one command request and hold it until the block takes it.
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = tx_quiet ? 0 : gap_length();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    // Stop sending until every expected result has come back.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, with stretches of steady ready.
    initial begin
        int stall_left;
        int phase_cnt;
        stall_left    = 0;
        phase_cnt     = 0;
        rx_quiet      = 1'b0;
        rsp_if.ready  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase_cnt == 0) begin
                rx_quiet  = ($urandom_range(0, 3) == 0);
                phase_cnt = int'($urandom_range(20, 120));
            end
            phase_cnt--;
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 2) == 0) begin
                    stall_left = gap_length();
                end
            end
        end
    end

    // Command stimulus and verdict.
    initial begin
        tx_quiet     = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        i_rst_n      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A resend before any reply returns the cleared reply register.
        send_cmd(make_cmd(CMD_RESEND, 8'd0, 8'd0, 16'd0));

        // Time commands at and just past the range limits.
        send_cmd(make_cmd(CMD_TIME, 8'd0, 8'd0, 16'd0));
        send_cmd(make_cmd(CMD_TIME, 8'd23, 8'd59, 16'hFFFF));
        send_cmd(make_cmd(CMD_TIME, 8'd24, 8'd0, 16'd0));
        send_cmd(make_cmd(CMD_TIME, 8'd0, 8'd60, 16'd0));
        send_cmd(make_cmd(CMD_TIME, 8'hFF, 8'hFF, 16'd2000));

        // A resend repeats the rejection and then again.
        send_cmd(make_cmd(CMD_RESEND, 8'hFF, 8'hFF, 16'hFFFF));
        send_cmd(make_cmd(CMD_RESEND, 8'd12, 8'd30, 16'd2024));

        // Date commands at the limits and just outside them.
        send_cmd(make_cmd(CMD_DATE, 8'd1, 8'd1, 16'd1980));
        send_cmd(make_cmd(CMD_DATE, 8'd31, 8'd12, 16'd2099));
        send_cmd(make_cmd(CMD_RESEND, 8'd0, 8'd0, 16'd0));
        send_cmd(make_cmd(CMD_DATE, 8'd0, 8'd1, 16'd2000));
        send_cmd(make_cmd(CMD_DATE, 8'd32, 8'd1, 16'd2000));
        send_cmd(make_cmd(CMD_DATE, 8'd1, 8'd0, 16'd2000));
        send_cmd(make_cmd(CMD_DATE, 8'd1, 8'd13, 16'd2000));
        send_cmd(make_cmd(CMD_DATE, 8'd1, 8'd1, 16'd1979));
        send_cmd(make_cmd(CMD_DATE, 8'd1, 8'd1, 16'd2100));
        send_cmd(make_cmd(CMD_DATE, 8'hFF, 8'hFF, 16'hFFFF));

        // Day past the end of its month is accepted; years before 2000 wrap.
        send_cmd(make_cmd(CMD_DATE, 8'd31, 8'd2, 16'd2023));
        send_cmd(make_cmd(CMD_DATE, 8'd15, 8'd6, 16'd1999));
        send_cmd(make_cmd(CMD_DATE, 8'd29, 8'd2, 16'd2000));

        // Unknown type bytes, including the reply code itself.
        send_cmd(make_cmd(8'h00, 8'd1, 8'd1, 16'd2000));
        send_cmd(make_cmd(8'hFF, 8'd0, 8'd0, 16'd0));
        send_cmd(make_cmd(REPLY_OK, 8'd10, 8'd10, 16'd2010));
        send_cmd(make_cmd(CMD_RESEND, 8'd0, 8'd0, 16'd0));
        wait_drained();

        // Random part, with a full pause partway through.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (n == 300) begin
                wait_drained();
            end
            send_cmd(random_cmd());
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
